[sv/esamp_pkg.sv]
// Shared types and constants for the equirectangular bilinear sampler.
package esamp_pkg;

   localparam int KIND_W       = 1;
   localparam int COLUMN_W     = 9;
   localparam int ROW_W        = 8;
   localparam int TEXEL_W      = 16;
   localparam int LON_W        = 17;
   localparam int LAT_W        = 16;
   localparam int HEIGHT_Q8_W  = 24;
   localparam int MAP_WIDTH_W  = 10;
   localparam int MAP_HEIGHT_W = 9;
   localparam int ANGLE_FRAC_W = 16;
   localparam int OUT_FRAC_W   = 8;
   localparam int NUM_TAPS     = 4;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_HEIGHT = 2'd1;

   localparam logic [MAP_WIDTH_W-1:0]  MAP_WIDTH_RESET  = 10'd512;
   localparam logic [MAP_HEIGHT_W-1:0] MAP_HEIGHT_RESET = 9'd256;

   typedef logic [MAP_WIDTH_W-1:0]  col_type;
   typedef logic [MAP_HEIGHT_W-1:0] row_type;
   typedef logic [TEXEL_W-1:0]      texel_type;

   typedef struct packed {
      logic valid;
      logic sample;
   } stage_ctl_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      texel_type           value;
   } texel_wr_type;

endpackage

[sv/esamp_coord.sv]
// Angle to pixel coordinate stages: scale, wrap columns, clamp rows, split fractions.
module esamp_coord #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [esamp_pkg::KIND_W-1:0]             in_kind,
   input  esamp_pkg::texel_wr_type                  in_wr,
   input  logic signed [esamp_pkg::LON_W-1:0]       in_lon,
   input  logic signed [esamp_pkg::LAT_W-1:0]       in_lat,
   input  esamp_pkg::col_type                       map_w,
   input  esamp_pkg::row_type                       map_h,
   output esamp_pkg::stage_ctl_type                 out_ctl,
   output esamp_pkg::texel_wr_type                  out_wr,
   output esamp_pkg::col_type                       out_c0,
   output esamp_pkg::col_type                       out_c1,
   output esamp_pkg::row_type                       out_r0,
   output esamp_pkg::row_type                       out_r1,
   output logic [FRAC_BITS-1:0]                     out_fx,
   output logic [FRAC_BITS-1:0]                     out_fy
);
   import esamp_pkg::*;

   localparam int MX_W  = LON_W + MAP_WIDTH_W + 1;
   localparam int XA_W  = MX_W + 1;
   localparam int MY_W  = LAT_W + MAP_HEIGHT_W + 1;
   localparam int YB_W  = MY_W + 2;
   localparam int IX_W  = XA_W - ANGLE_FRAC_W + 1;
   localparam int IY_W  = YB_W - ANGLE_FRAC_W + 1;
   localparam int SEL_W = ANGLE_FRAC_W + FRAC_BITS;
   localparam int HALF  = ANGLE_FRAC_W - 1;

   function automatic col_type wrap_col(input logic signed [IX_W-1:0] v, input col_type w);
      logic signed [IX_W-1:0] ws;
      logic signed [IX_W-1:0] r;
      ws = $signed({{(IX_W-MAP_WIDTH_W){1'b0}}, w});
      if (v < 0) begin
         r = v + ws;
      end else if (v >= ws) begin
         r = v - ws;
      end else begin
         r = v;
      end
      return r[MAP_WIDTH_W-1:0];
   endfunction

   function automatic row_type clamp_row(input logic signed [IY_W-1:0] v, input row_type h);
      logic signed [IY_W-1:0] top;
      row_type                r;
      top = $signed({{(IY_W-MAP_HEIGHT_W){1'b0}}, h}) - 1;
      if (v < 0) begin
         r = '0;
      end else if (v > top) begin
         r = top[MAP_HEIGHT_W-1:0];
      end else begin
         r = v[MAP_HEIGHT_W-1:0];
      end
      return r;
   endfunction

   // stage 1: scaled coordinates, 16 fractional bits
   logic signed [MX_W-1:0] mul_x;
   logic signed [MY_W-1:0] mul_y;
   logic signed [XA_W-1:0] xa_in, xa_ff;
   logic signed [YB_W-1:0] yb_in, yb_ff;
   col_type                w_m1;
   row_type                h_m1;
   stage_ctl_type          ctl1_in, ctl1_ff;
   texel_wr_type           wr1_ff;

   always_comb begin
      w_m1  = map_w - 1'b1;
      h_m1  = map_h - 1'b1;
      mul_x = in_lon * $signed({1'b0, map_w});
      mul_y = in_lat * $signed({1'b0, map_h});
      xa_in = {mul_x[MX_W-1], mul_x}
            + $signed({{(XA_W-MAP_WIDTH_W-HALF){1'b0}}, w_m1, {HALF{1'b0}}});
      yb_in = $signed({{(YB_W-MAP_HEIGHT_W-HALF){1'b0}}, h_m1, {HALF{1'b0}}})
            - $signed({mul_y[MY_W-1], mul_y, 1'b0});
      ctl1_in.valid  = in_valid;
      ctl1_in.sample = (in_kind == KIND_SAMPLE);
   end

   // stage 2: neighbor columns and rows, fractions
   logic signed [IX_W-1:0] ix0, ix1;
   logic signed [IY_W-1:0] iy0, iy1;
   logic [SEL_W-1:0]       sel_x, sel_y;
   col_type                c0_in, c1_in, c0_ff, c1_ff;
   row_type                r0_in, r1_in, r0_ff, r1_ff;
   logic [FRAC_BITS-1:0]   fx_in, fy_in, fx_ff, fy_ff;
   stage_ctl_type          ctl2_ff;
   texel_wr_type           wr2_ff;

   always_comb begin
      ix0   = {xa_ff[XA_W-1], xa_ff[XA_W-1:ANGLE_FRAC_W]};
      ix1   = ix0 + 1'b1;
      iy0   = {yb_ff[YB_W-1], yb_ff[YB_W-1:ANGLE_FRAC_W]};
      iy1   = iy0 + 1'b1;
      c0_in = wrap_col(ix0, map_w);
      c1_in = wrap_col(ix1, map_w);
      r0_in = clamp_row(iy0, map_h);
      r1_in = clamp_row(iy1, map_h);
      sel_x = {xa_ff[ANGLE_FRAC_W-1:0], {FRAC_BITS{1'b0}}};
      sel_y = {yb_ff[ANGLE_FRAC_W-1:0], {FRAC_BITS{1'b0}}};
      fx_in = sel_x[SEL_W-1 -: FRAC_BITS];
      fy_in = sel_y[SEL_W-1 -: FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff  <= xa_in;
      yb_ff  <= yb_in;
      wr1_ff <= in_wr;
      c0_ff  <= c0_in;
      c1_ff  <= c1_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      fx_ff  <= fx_in;
      fy_ff  <= fy_in;
      wr2_ff <= wr1_ff;
   end

   assign out_ctl = ctl2_ff;
   assign out_wr  = wr2_ff;
   assign out_c0  = c0_ff;
   assign out_c1  = c1_ff;
   assign out_r0  = r0_ff;
   assign out_r1  = r1_ff;
   assign out_fx  = fx_ff;
   assign out_fy  = fy_ff;

   a_col_adjacent: assert property (@(posedge clock) disable iff (reset)
      ctl1_ff.valid && ctl1_ff.sample |-> (c1_in == c0_in + 1'b1) || (c1_in == '0))
      else $error("right column is not next to left column");

   a_row_adjacent: assert property (@(posedge clock) disable iff (reset)
      ctl1_ff.valid && ctl1_ff.sample |-> (r1_in == r0_in) || (r1_in == r0_in + 1'b1))
      else $error("lower row is not next to upper row");

endmodule

[sv/esamp_fetch.sv]
// Texel address stage and four replicated copies of the height store.
module esamp_fetch #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  esamp_pkg::stage_ctl_type                      in_ctl,
   input  esamp_pkg::texel_wr_type                       in_wr,
   input  esamp_pkg::col_type                            in_c0,
   input  esamp_pkg::col_type                            in_c1,
   input  esamp_pkg::row_type                            in_r0,
   input  esamp_pkg::row_type                            in_r1,
   input  logic [FRAC_BITS-1:0]                          in_fx,
   input  logic [FRAC_BITS-1:0]                          in_fy,
   output esamp_pkg::stage_ctl_type                      out_ctl,
   output logic [esamp_pkg::NUM_TAPS-1:0][esamp_pkg::TEXEL_W-1:0] out_texels,
   output logic [FRAC_BITS-1:0]                          out_fx,
   output logic [FRAC_BITS-1:0]                          out_fy
);
   import esamp_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   function automatic logic [ADDR_W-1:0] texel_addr(input logic [31:0] col,
                                                    input logic [31:0] row);
      logic [31:0] lin;
      lin = row * MAX_WIDTH + col;
      return lin[ADDR_W-1:0];
   endfunction

   // stage 3: addresses; tap order is (c0,r0) (c0,r1) (c1,r0) (c1,r1)
   logic [NUM_TAPS-1:0][ADDR_W-1:0] addr_in, addr_ff;
   logic                            wr_ok;
   logic                            we_in, we_ff;
   texel_type                       wdata_ff;
   stage_ctl_type                   ctl3_ff, ctl4_ff;
   logic [FRAC_BITS-1:0]            fx3_ff, fy3_ff, fx4_ff, fy4_ff;

   always_comb begin
      wr_ok = (32'(in_wr.column) < MAX_WIDTH) && (32'(in_wr.row) < MAX_HEIGHT);
      we_in = in_ctl.valid && !in_ctl.sample && wr_ok;
      addr_in[0] = in_ctl.sample ? texel_addr(32'(in_c0), 32'(in_r0))
                                 : texel_addr(32'(in_wr.column), 32'(in_wr.row));
      addr_in[1] = texel_addr(32'(in_c0), 32'(in_r1));
      addr_in[2] = texel_addr(32'(in_c1), 32'(in_r0));
      addr_in[3] = texel_addr(32'(in_c1), 32'(in_r1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
         we_ff   <= 1'b0;
         ctl4_ff <= '0;
      end else begin
         ctl3_ff       <= in_ctl;
         we_ff         <= we_in;
         // writes leave the pipeline here
         ctl4_ff.valid  <= ctl3_ff.valid && ctl3_ff.sample;
         ctl4_ff.sample <= ctl3_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      wdata_ff <= in_wr.value;
      fx3_ff   <= in_fx;
      fy3_ff   <= in_fy;
      fx4_ff   <= fx3_ff;
      fy4_ff   <= fy3_ff;
   end

   // stage 4: every copy takes each write, each copy serves one tap
   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_copy
      texel_type copy_mem [DEPTH];
      texel_type rd_ff;

      always_ff @(posedge clock) begin
         if (we_ff) begin
            copy_mem[addr_ff[0]] <= wdata_ff;
         end
         rd_ff <= copy_mem[addr_ff[k]];
      end

      assign out_texels[k] = rd_ff;
   end

   assign out_ctl = ctl4_ff;
   assign out_fx  = fx4_ff;
   assign out_fy  = fy4_ff;

endmodule

[sv/esamp_blend.sv]
// Bilinear blend: vertical pair sums, split horizontal products, final sum and truncation.
module esamp_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  esamp_pkg::stage_ctl_type                               in_ctl,
   input  logic [esamp_pkg::NUM_TAPS-1:0][esamp_pkg::TEXEL_W-1:0] in_texels,
   input  logic [FRAC_BITS-1:0]                                   in_fx,
   input  logic [FRAC_BITS-1:0]                                   in_fy,
   output logic                                                   out_valid,
   output logic [esamp_pkg::HEIGHT_Q8_W-1:0]                      out_height_q8
);
   import esamp_pkg::*;

   localparam int WT_W  = FRAC_BITS + 1;
   localparam int PS_W  = TEXEL_W + WT_W;
   localparam int LW    = TEXEL_W + FRAC_BITS;
   localparam int LO_W  = LW / 2;
   localparam int HI_W  = LW - LO_W;
   localparam int PLO_W = LO_W + WT_W;
   localparam int PHI_W = HI_W + WT_W;
   localparam int ACC_W = TEXEL_W + 2 * FRAC_BITS;
   localparam int SHIFT = 2 * FRAC_BITS - OUT_FRAC_W;
   localparam logic [WT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // stage 5: blend down each column
   logic [WT_W-1:0]      wfy, fye;
   logic [PS_W-1:0]      l_sum, r_sum;
   logic [LW-1:0]        l_ff, r_ff;
   logic [FRAC_BITS-1:0] fx5_ff;
   logic                 v5_ff;

   always_comb begin
      fye   = {1'b0, in_fy};
      wfy   = ONE - fye;
      l_sum = in_texels[0] * wfy + in_texels[1] * fye;
      r_sum = in_texels[2] * wfy + in_texels[3] * fye;
   end

   // stage 6: horizontal weights, operands split in halves
   logic [WT_W-1:0]  wfx, fxe;
   logic [PLO_W-1:0] pll_ff, prl_ff;
   logic [PHI_W-1:0] plh_ff, prh_ff;
   logic             v6_ff;

   always_comb begin
      fxe = {1'b0, fx5_ff};
      wfx = ONE - fxe;
   end

   // stage 7: recombine and truncate
   logic [ACC_W-1:0]       acc;
   logic [HEIGHT_Q8_W-1:0] q8_ff;
   logic                   v7_ff;

   always_comb begin
      acc = ACC_W'({plh_ff, {LO_W{1'b0}}}) + ACC_W'(pll_ff)
          + ACC_W'({prh_ff, {LO_W{1'b0}}}) + ACC_W'(prl_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v5_ff <= in_ctl.valid && in_ctl.sample;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      l_ff   <= l_sum[LW-1:0];
      r_ff   <= r_sum[LW-1:0];
      fx5_ff <= in_fx;
      pll_ff <= l_ff[LO_W-1:0] * wfx;
      plh_ff <= l_ff[LW-1:LO_W] * wfx;
      prl_ff <= r_ff[LO_W-1:0] * fxe;
      prh_ff <= r_ff[LW-1:LO_W] * fxe;
      q8_ff  <= acc[SHIFT +: HEIGHT_Q8_W];
   end

   assign out_valid     = v7_ff;
   assign out_height_q8 = q8_ff;

endmodule

[sv/equirect_bilinear_sampler_unit.sv]
// Top level of the equirectangular bilinear height-map sampler.
// Takes one transaction per clock (texel write or sample) and never raises busy.
// A sample returns its height on rsp_valid after passing through
// seven register stages, which run coordinate scaling, wrap and clamp, address
// forming, store read, column blend, split horizontal products and the final
// sum. Four copies of the height store, each written by every texel write,
// give the four neighbor reads in the same cycle. Writes produce no response and
// stay in order with samples, so a sample sees exactly the writes started
// before it. Entries never written read as arbitrary data. rsp_valid lasts
// one cycle and cannot be held off. Map size registers take effect at once.
module equirect_bilinear_sampler_unit #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [esamp_pkg::KIND_W-1:0]           req_kind,
   input  logic [esamp_pkg::COLUMN_W-1:0]         req_texel_column,
   input  logic [esamp_pkg::ROW_W-1:0]            req_texel_row,
   input  logic [esamp_pkg::TEXEL_W-1:0]          req_texel_value,
   input  logic signed [esamp_pkg::LON_W-1:0]     req_lon_angle,
   input  logic signed [esamp_pkg::LAT_W-1:0]     req_lat_angle,
   output logic                                   rsp_valid,
   output logic [esamp_pkg::HEIGHT_Q8_W-1:0]      rsp_height_q8,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [esamp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [esamp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import esamp_pkg::*;

   localparam int LATENCY = 7;

   col_type map_width_ff;
   row_type map_height_ff;
   col_type map_w;
   row_type map_h;
   logic    accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_WIDTH_RESET;
         map_height_ff <= MAP_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MAP_WIDTH:  map_width_ff  <= csr_wdata[MAP_WIDTH_W-1:0];
            REG_MAP_HEIGHT: map_height_ff <= csr_wdata[MAP_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the map size to [1, maximum]
   always_comb begin
      if (map_width_ff == '0) begin
         map_w = col_type'(1);
      end else if (32'(map_width_ff) > MAX_WIDTH) begin
         map_w = MAP_WIDTH_W'(MAX_WIDTH);
      end else begin
         map_w = map_width_ff;
      end
      if (map_height_ff == '0) begin
         map_h = row_type'(1);
      end else if (32'(map_height_ff) > MAX_HEIGHT) begin
         map_h = MAP_HEIGHT_W'(MAX_HEIGHT);
      end else begin
         map_h = map_height_ff;
      end
   end

   texel_wr_type  req_wr;
   stage_ctl_type coord_ctl, fetch_ctl;
   texel_wr_type  coord_wr;
   col_type       c0, c1;
   row_type       r0, r1;
   logic [FRAC_BITS-1:0] coord_fx, coord_fy, fetch_fx, fetch_fy;
   logic [NUM_TAPS-1:0][TEXEL_W-1:0] texels;

   always_comb begin
      req_wr.column = req_texel_column;
      req_wr.row    = req_texel_row;
      req_wr.value  = req_texel_value;
   end

   esamp_coord #(
      .FRAC_BITS (FRAC_BITS)
   ) u_coord (
      .clock   (clock),
      .reset   (reset),
      .in_valid(accept),
      .in_kind (req_kind),
      .in_wr   (req_wr),
      .in_lon  (req_lon_angle),
      .in_lat  (req_lat_angle),
      .map_w   (map_w),
      .map_h   (map_h),
      .out_ctl (coord_ctl),
      .out_wr  (coord_wr),
      .out_c0  (c0),
      .out_c1  (c1),
      .out_r0  (r0),
      .out_r1  (r1),
      .out_fx  (coord_fx),
      .out_fy  (coord_fy)
   );

   esamp_fetch #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .FRAC_BITS (FRAC_BITS)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (coord_ctl),
      .in_wr     (coord_wr),
      .in_c0     (c0),
      .in_c1     (c1),
      .in_r0     (r0),
      .in_r1     (r1),
      .in_fx     (coord_fx),
      .in_fy     (coord_fy),
      .out_ctl   (fetch_ctl),
      .out_texels(texels),
      .out_fx    (fetch_fx),
      .out_fy    (fetch_fy)
   );

   esamp_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock        (clock),
      .reset        (reset),
      .in_ctl       (fetch_ctl),
      .in_texels    (texels),
      .in_fx        (fetch_fx),
      .in_fy        (fetch_fy),
      .out_valid    (rsp_valid),
      .out_height_q8(rsp_height_q8)
   );

   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && (req_kind == KIND_SAMPLE), LATENCY))
      else $error("response without a sample transaction seven cycles earlier");

endmodule
